// ===== hdl/rsi_pkg.sv =====
// Shared types, constants and fixed-point helpers for the saddle intersector.
`timescale 1ns / 1ps

package rsi_pkg;

    localparam int WORD_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int ROOT_W     = 24;
    localparam int SQ_STAGES  = 24;
    localparam int DIV_BITS   = 48;
    localparam int DIV_STAGES = 24;

    localparam logic signed [63:0] W_MAX     = 64'sd2147483647;
    localparam logic signed [63:0] W_MIN     = -64'sd2147483648;
    localparam logic signed [63:0] FRAC_MASK = 64'sd65535;

    localparam logic [1:0] REG_EPSILON = 2'd0;
    localparam logic [1:0] REG_BOX_MIN = 2'd1;
    localparam logic [1:0] REG_BOX_MAX = 2'd2;

    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic signed [31:0] nearest;
        logic               prior;
    } t_ray;

    typedef struct packed {
        t_ray               ray;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] disc;
    } t_quad;

    typedef struct packed {
        t_ray        ray;
        logic        ok1;
        logic        ok2;
        logic        neg1;
        logic        neg2;
        logic [32:0] den;
    } t_dctx;

    typedef struct packed {
        t_ray               ray;
        logic               ok1;
        logic               ok2;
        logic signed [31:0] t1;
        logic signed [31:0] t2;
    } t_cand;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > W_MAX) begin
            return 32'sh7fffffff;
        end else if (v < W_MIN) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] smul(input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
        return 64'(x) * 64'(y);
    endfunction

    // drop fraction bits rounding toward zero, then clamp
    function automatic logic signed [31:0] qfix(input logic signed [63:0] p);
        logic signed [63:0] adj;
        adj = p[63] ? p + FRAC_MASK : p;
        return sat32(adj >>> FRAC_W);
    endfunction

    function automatic logic signed [31:0] from_mag(input logic [47:0] q, input logic neg);
        logic [31:0] lo;
        lo = q[31:0];
        if (neg) begin
            if (q > 48'd2147483648) return 32'sh80000000;
            return 32'(-lo);
        end
        if (q > 48'd2147483647) return 32'sh7fffffff;
        return lo;
    endfunction

    // one restoring divide bit: {quotient bit, new remainder}
    function automatic logic [33:0] div_step(input logic [32:0] rem, input logic [32:0] den,
                                             input logic nbit);
        logic [33:0] sh;
        sh = {rem, nbit};
        if (sh >= {1'b0, den}) begin
            return {1'b1, 33'(sh - {1'b0, den})};
        end
        return {1'b0, sh[32:0]};
    endfunction

    // one restoring square-root bit: {root bit, new remainder}
    function automatic logic [28:0] sqrt_step(input logic [27:0] r, input logic [23:0] q,
                                              input logic [1:0] pair);
        logic [27:0] rr;
        logic [27:0] tt;
        rr = {r[25:0], pair};
        tt = {2'b00, q, 2'b01};
        if (rr >= tt) begin
            return {1'b1, 28'(rr - tt)};
        end
        return {1'b0, rr};
    endfunction

endpackage

// ===== hdl/rsi_front.sv =====
// Quadratic setup: forms a, b, c and the discriminant over seven stages.
`timescale 1ns / 1ps

module rsi_front import rsi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_ray  i_ray,
    output logic  o_valid,
    output t_quad o_quad
);

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    t_ray r_ray1, r_ray2, r_ray3, r_ray4, r_ray5, r_ray6;
    logic signed [63:0] r_pxy, r_pyox, r_pxoy, r_poo;
    logic signed [31:0] r_qxy, r_qyox, r_qxoy, r_qoo;
    logic signed [31:0] r_a3, r_sbo, r_c3;
    logic signed [31:0] r_a4, r_b4, r_c4;
    logic signed [31:0] r_a5, r_b5;
    logic signed [63:0] r_pbb, r_pac;
    logic signed [31:0] r_a6, r_b6, r_qbb, r_qac;
    t_quad r_quad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ray1 <= i_ray;
            r_pxy  <= smul(i_ray.dx, i_ray.dy);
            r_pyox <= smul(i_ray.dy, i_ray.ox);
            r_pxoy <= smul(i_ray.dx, i_ray.oy);
            r_poo  <= smul(i_ray.ox, i_ray.oy);

            r_ray2 <= r_ray1;
            r_qxy  <= qfix(r_pxy);
            r_qyox <= qfix(r_pyox);
            r_qxoy <= qfix(r_pxoy);
            r_qoo  <= qfix(r_poo);

            r_ray3 <= r_ray2;
            r_a3   <= sat32(-64'(r_qxy));
            r_sbo  <= sat32(64'(r_qyox) + 64'(r_qxoy));
            r_c3   <= sat32(64'(r_ray2.oz) - 64'(r_qoo));

            r_ray4 <= r_ray3;
            r_a4   <= r_a3;
            r_b4   <= sat32(64'(r_ray3.dz) - 64'(r_sbo));
            r_c4   <= r_c3;

            r_ray5 <= r_ray4;
            r_a5   <= r_a4;
            r_b5   <= r_b4;
            r_pbb  <= smul(r_b4, r_b4);
            r_pac  <= smul(r_a4, r_c4);

            r_ray6 <= r_ray5;
            r_a6   <= r_a5;
            r_b6   <= r_b5;
            r_qbb  <= qfix(r_pbb);
            r_qac  <= qfix(r_pac);

            r_quad.ray  <= r_ray6;
            r_quad.a    <= r_a6;
            r_quad.b    <= r_b6;
            r_quad.disc <= sat32(64'(r_qbb) - 64'(sat32(64'(r_qac) <<< 2)));
        end
    end

    assign o_valid = r_v7;
    assign o_quad  = r_quad;

endmodule

// ===== hdl/rsi_sqrt.sv =====
// Pipelined square root of the discriminant, one root bit per stage.
`timescale 1ns / 1ps

module rsi_sqrt import rsi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_quad             i_quad,
    output logic              o_valid,
    output t_quad             o_quad,
    output logic [ROOT_W-1:0] o_root
);

    logic        w_v    [0:SQ_STAGES];
    t_quad       w_quad [0:SQ_STAGES];
    logic [27:0] w_r    [0:SQ_STAGES];
    logic [23:0] w_q    [0:SQ_STAGES];
    logic [47:0] w_rad  [0:SQ_STAGES];

    assign w_v[0]    = i_valid;
    assign w_quad[0] = i_quad;
    assign w_r[0]    = '0;
    assign w_q[0]    = '0;
    assign w_rad[0]  = {1'b0, i_quad.disc[30:0], 16'b0};

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        logic        r_v;
        t_quad       r_quad;
        logic [27:0] r_r;
        logic [23:0] r_q;
        logic [47:0] r_rad;
        logic [28:0] n_step;

        assign n_step = sqrt_step(w_r[k], w_q[k], w_rad[k][47:46]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quad <= w_quad[k];
                r_r    <= n_step[27:0];
                r_q    <= {w_q[k][22:0], n_step[28]};
                r_rad  <= {w_rad[k][45:0], 2'b00};
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_quad[k+1] = r_quad;
        assign w_r[k+1]    = r_r;
        assign w_q[k+1]    = r_q;
        assign w_rad[k+1]  = r_rad;
    end

    assign o_valid = w_v[SQ_STAGES];
    assign o_quad  = w_quad[SQ_STAGES];
    assign o_root  = w_q[SQ_STAGES];

endmodule

// ===== hdl/rsi_div.sv =====
// Candidate distances: numerator setup and a two-lane pipelined divider.
`timescale 1ns / 1ps

module rsi_div import rsi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_quad             i_quad,
    input  logic [ROOT_W-1:0] i_root,
    input  logic [15:0]       i_eps,
    output logic              o_valid,
    output t_cand             o_cand
);

    logic signed [31:0] eps32, s_sg, nb, nm1, nm2;
    logic        [32:0] mag_a;
    logic        [31:0] m1, m2;
    logic               a_nz;
    t_dctx              n_ctx;

    always_comb begin
        eps32 = signed'({16'b0, i_eps});
        s_sg  = i_quad.a[31] ? -signed'({8'b0, i_root}) : signed'({8'b0, i_root});
        nb    = sat32(-64'(i_quad.b));
        nm1   = i_quad.ray.prior ? i_quad.b : sat32(64'(nb) - 64'(s_sg));
        nm2   = sat32(64'(nb) + 64'(s_sg));
        mag_a = i_quad.a[31] ? 33'(33'd0 - {i_quad.a[31], i_quad.a}) : {1'b0, i_quad.a};
        m1    = nm1[31] ? 32'(32'd0 - nm1) : nm1;
        m2    = nm2[31] ? 32'(32'd0 - nm2) : nm2;
        a_nz  = (i_quad.a != '0);

        n_ctx.ray  = i_quad.ray;
        n_ctx.ok1  = a_nz && (i_quad.ray.prior ? (64'(i_quad.b) + 64'(eps32) < 0)
                                               : (i_quad.disc >= eps32));
        n_ctx.ok2  = a_nz && !i_quad.ray.prior && (i_quad.disc >= eps32);
        n_ctx.neg1 = nm1[31] ^ i_quad.a[31];
        n_ctx.neg2 = nm2[31] ^ i_quad.a[31];
        n_ctx.den  = i_quad.ray.prior ? mag_a : {mag_a[31:0], 1'b0};
    end

    logic              w_v    [0:DIV_STAGES];
    t_dctx             w_ctx  [0:DIV_STAGES];
    logic [47:0]       w_n1   [0:DIV_STAGES];
    logic [47:0]       w_n2   [0:DIV_STAGES];
    logic [32:0]       w_rem1 [0:DIV_STAGES];
    logic [32:0]       w_rem2 [0:DIV_STAGES];
    logic [47:0]       w_q1   [0:DIV_STAGES];
    logic [47:0]       w_q2   [0:DIV_STAGES];

    logic        r_ev;
    t_dctx       r_ectx;
    logic [47:0] r_en1, r_en2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= 1'b0;
        end else if (i_en) begin
            r_ev <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ectx <= n_ctx;
            r_en1  <= {m1, 16'b0};
            r_en2  <= {m2, 16'b0};
        end
    end

    assign w_v[0]    = r_ev;
    assign w_ctx[0]  = r_ectx;
    assign w_n1[0]   = r_en1;
    assign w_n2[0]   = r_en2;
    assign w_rem1[0] = '0;
    assign w_rem2[0] = '0;
    assign w_q1[0]   = '0;
    assign w_q2[0]   = '0;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic        r_v;
        t_dctx       r_ctx;
        logic [47:0] r_n1, r_n2, r_q1, r_q2;
        logic [32:0] r_rem1, r_rem2;
        logic [33:0] n_s1a, n_s1b, n_s2a, n_s2b;

        // two quotient bits per lane per stage
        assign n_s1a = div_step(w_rem1[k], w_ctx[k].den, w_n1[k][47]);
        assign n_s1b = div_step(n_s1a[32:0], w_ctx[k].den, w_n1[k][46]);
        assign n_s2a = div_step(w_rem2[k], w_ctx[k].den, w_n2[k][47]);
        assign n_s2b = div_step(n_s2a[32:0], w_ctx[k].den, w_n2[k][46]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctx  <= w_ctx[k];
                r_n1   <= {w_n1[k][45:0], 2'b00};
                r_n2   <= {w_n2[k][45:0], 2'b00};
                r_rem1 <= n_s1b[32:0];
                r_rem2 <= n_s2b[32:0];
                r_q1   <= {w_q1[k][45:0], n_s1a[33], n_s1b[33]};
                r_q2   <= {w_q2[k][45:0], n_s2a[33], n_s2b[33]};
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_ctx[k+1]  = r_ctx;
        assign w_n1[k+1]   = r_n1;
        assign w_n2[k+1]   = r_n2;
        assign w_rem1[k+1] = r_rem1;
        assign w_rem2[k+1] = r_rem2;
        assign w_q1[k+1]   = r_q1;
        assign w_q2[k+1]   = r_q2;
    end

    logic  r_fv;
    t_cand r_cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (i_en) begin
            r_fv <= w_v[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cand.ray <= w_ctx[DIV_STAGES].ray;
            r_cand.ok1 <= w_ctx[DIV_STAGES].ok1;
            r_cand.ok2 <= w_ctx[DIV_STAGES].ok2;
            r_cand.t1  <= from_mag(w_q1[DIV_STAGES], w_ctx[DIV_STAGES].neg1);
            r_cand.t2  <= from_mag(w_q2[DIV_STAGES], w_ctx[DIV_STAGES].neg2);
        end
    end

    assign o_valid = r_fv;
    assign o_cand  = r_cand;

endmodule

// ===== hdl/rsi_accept.sv =====
// Range and clipping-cube tests on both candidates, then pick the first accepted.
`timescale 1ns / 1ps

module rsi_accept import rsi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_cand              i_cand,
    input  logic [15:0]        i_eps,
    input  logic signed [31:0] i_box_min,
    input  logic signed [31:0] i_box_max,
    output logic               o_valid,
    output logic               o_hit,
    output logic signed [31:0] o_nearest
);

    logic signed [31:0] eps32;
    assign eps32 = signed'({16'b0, i_eps});

    logic r_v1, r_v2, r_v3, r_v4;
    logic r_g1 [1:3];
    logic r_g2 [1:3];
    logic signed [31:0] r_t1 [1:3];
    logic signed [31:0] r_t2 [1:3];
    logic signed [31:0] r_nr [1:3];
    logic signed [31:0] r_ox [1:2];
    logic signed [31:0] r_oy [1:2];
    logic signed [31:0] r_oz [1:2];
    logic signed [63:0] r_p  [0:5];
    logic signed [31:0] r_q  [0:5];
    logic signed [31:0] r_pt [0:5];
    logic               in1, in2, take1, take2;
    logic               r_hit;
    logic signed [31:0] r_near;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_comb begin
        in1 = 1'b1;
        in2 = 1'b1;
        for (int k = 0; k < 3; k++) begin
            in1 = in1 && (r_pt[k] >= i_box_min) && (r_pt[k] <= i_box_max);
            in2 = in2 && (r_pt[k+3] >= i_box_min) && (r_pt[k+3] <= i_box_max);
        end
        take1 = r_g1[3] && in1;
        take2 = r_g2[3] && in2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= smul(i_cand.t1, i_cand.ray.dx);
            r_p[1] <= smul(i_cand.t1, i_cand.ray.dy);
            r_p[2] <= smul(i_cand.t1, i_cand.ray.dz);
            r_p[3] <= smul(i_cand.t2, i_cand.ray.dx);
            r_p[4] <= smul(i_cand.t2, i_cand.ray.dy);
            r_p[5] <= smul(i_cand.t2, i_cand.ray.dz);
            r_g1[1] <= i_cand.ok1 && (eps32 < i_cand.t1) && (i_cand.t1 < i_cand.ray.nearest);
            r_g2[1] <= i_cand.ok2 && (eps32 < i_cand.t2) && (i_cand.t2 < i_cand.ray.nearest);
            r_t1[1] <= i_cand.t1;
            r_t2[1] <= i_cand.t2;
            r_nr[1] <= i_cand.ray.nearest;
            r_ox[1] <= i_cand.ray.ox;
            r_oy[1] <= i_cand.ray.oy;
            r_oz[1] <= i_cand.ray.oz;

            for (int k = 0; k < 6; k++) begin
                r_q[k] <= qfix(r_p[k]);
            end
            r_ox[2] <= r_ox[1];
            r_oy[2] <= r_oy[1];
            r_oz[2] <= r_oz[1];

            r_pt[0] <= sat32(64'(r_ox[2]) + 64'(r_q[0]));
            r_pt[1] <= sat32(64'(r_oy[2]) + 64'(r_q[1]));
            r_pt[2] <= sat32(64'(r_oz[2]) + 64'(r_q[2]));
            r_pt[3] <= sat32(64'(r_ox[2]) + 64'(r_q[3]));
            r_pt[4] <= sat32(64'(r_oy[2]) + 64'(r_q[4]));
            r_pt[5] <= sat32(64'(r_oz[2]) + 64'(r_q[5]));

            for (int s = 2; s <= 3; s++) begin
                r_g1[s] <= r_g1[s-1];
                r_g2[s] <= r_g2[s-1];
                r_t1[s] <= r_t1[s-1];
                r_t2[s] <= r_t2[s-1];
                r_nr[s] <= r_nr[s-1];
            end

            // the first root wins when both pass
            r_hit  <= take1 || take2;
            r_near <= take1 ? r_t1[3] : (take2 ? r_t2[3] : r_nr[3]);
        end
    end

    assign o_valid   = r_v4;
    assign o_hit     = r_hit;
    assign o_nearest = r_near;

endmodule

// ===== hdl/ray_saddle_intersect.sv =====
// Top level of the ray against clipped saddle (z = x*y) intersector.
//
// Usage:
//   Rays enter on the input channel (i_valid / o_stall) with origin, direction
//   and the current nearest distance, all signed Q16.16, and the prior-hit flag.
//   Each ray yields exactly one result beat on the output channel
//   (o_valid / i_stall): o_hit and the updated nearest distance.
//   Each accepted ray passes in order through quadratic setup, square root (one
//   root bit per stage), division (two quotient bits per stage plus setup and
//   sign fix) and clipping tests. Throughput is one ray per cycle while the
//   output is not stalled, set by the fully pipelined multipliers, root and
//   divider stages.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   o_stall rises; nothing is dropped or repeated.
//   The APB port sets epsilon, box_min and box_max; write them only while no
//   ray is in flight. pready is tied high.
//   Reset (i_rst_n low, synchronous) empties the pipeline and loads
//   epsilon = 1, box_min = -1.0, box_max = +1.0.
`timescale 1ns / 1ps

module ray_saddle_intersect import rsi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_origin_x,
    input  logic signed [31:0] i_origin_y,
    input  logic signed [31:0] i_origin_z,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_dir_z,
    input  logic signed [31:0] i_nearest_in,
    input  logic               i_prior_hit,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_hit,
    output logic signed [31:0] o_nearest_out
);

    logic [15:0]        r_eps;
    logic signed [31:0] r_box_min, r_box_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps     <= 16'd1;
            r_box_min <= -32'sd65536;
            r_box_max <= 32'sd65536;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_EPSILON: r_eps     <= pwdata[15:0];
                REG_BOX_MIN: r_box_min <= pwdata;
                REG_BOX_MAX: r_box_max <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_EPSILON: prdata = {16'b0, r_eps};
            REG_BOX_MIN: prdata = r_box_min;
            REG_BOX_MAX: prdata = r_box_max;
            default:     prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    logic  adv;
    logic  out_v, fr_v, sq_v, dv_v;
    t_ray  in_ray;
    t_quad fr_quad, sq_quad;
    t_cand dv_cand;
    logic [ROOT_W-1:0] sq_root;

    // hold every stage while a finished beat waits at the output
    assign adv     = !(out_v && i_stall);
    assign o_stall = !adv;
    assign o_valid = out_v;

    always_comb begin
        in_ray.ox      = i_origin_x;
        in_ray.oy      = i_origin_y;
        in_ray.oz      = i_origin_z;
        in_ray.dx      = i_dir_x;
        in_ray.dy      = i_dir_y;
        in_ray.dz      = i_dir_z;
        in_ray.nearest = i_nearest_in;
        in_ray.prior   = i_prior_hit;
    end

    rsi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_valid),
        .i_ray   (in_ray),
        .o_valid (fr_v),
        .o_quad  (fr_quad)
    );

    rsi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (fr_v),
        .i_quad  (fr_quad),
        .o_valid (sq_v),
        .o_quad  (sq_quad),
        .o_root  (sq_root)
    );

    rsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (sq_v),
        .i_quad  (sq_quad),
        .i_root  (sq_root),
        .i_eps   (r_eps),
        .o_valid (dv_v),
        .o_cand  (dv_cand)
    );

    rsi_accept u_accept (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_valid   (dv_v),
        .i_cand    (dv_cand),
        .i_eps     (r_eps),
        .i_box_min (r_box_min),
        .i_box_max (r_box_max),
        .o_valid   (out_v),
        .o_hit     (o_hit),
        .o_nearest (o_nearest_out)
    );

endmodule

// ===== hdl/rsi_chk.sv =====
// Port-level checker for the saddle intersector, bound to the top level.
`timescale 1ns / 1ps

module rsi_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_stall,
    input logic        o_valid,
    input logic        o_stall,
    input logic        o_hit,
    input logic [31:0] o_nearest_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_hit) && $stable(o_nearest_out))
        else $error("output payload changed while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked output beat");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

endmodule

bind ray_saddle_intersect rsi_chk u_rsi_chk (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the saddle intersector: random and directed rays, checked against a predictor.
`timescale 1ns / 1ps

import rsi_pkg::*;

class ray_scoreboard;
    longint eps;
    longint bmin;
    longint bmax;
    bit     exp_hit[$];
    int     exp_near[$];
    int     errors;
    int     checked;
    int     hits;

    function new();
        eps = 1;
        bmin = -65536;
        bmax = 65536;
        errors = 0;
        checked = 0;
        hits = 0;
    endfunction

    function longint clamp(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function longint unsigned mag(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function longint from_mag(longint unsigned m, bit neg);
        if (neg) return (m > 64'd2147483648) ? -64'sd2147483648 : -longint'(m);
        return (m > 64'd2147483647) ? 64'sd2147483647 : longint'(m);
    endfunction

    function longint fx_mul(longint x, longint y);
        longint unsigned p;
        p = mag(x) * mag(y);
        return from_mag(p >> FRAC_W, (x < 0) != (y < 0));
    endfunction

    function longint fx_div(longint n, longint d);
        longint unsigned q;
        q = (mag(n) << FRAC_W) / mag(d);
        return from_mag(q, (n < 0) != (d < 0));
    endfunction

    // truncated root of d in fixed point: floor(sqrt(d << frac))
    function longint fx_sqrt(longint d);
        longint unsigned v;
        longint unsigned r;
        longint unsigned c;
        v = longint'(d) << FRAC_W;
        r = 0;
        for (int i = 25; i >= 0; i--) begin
            c = r | (64'd1 << i);
            if (c * c <= v) r = c;
        end
        return longint'(r);
    endfunction

    function bit in_box(longint o, longint t, longint d);
        longint p;
        p = clamp(o + fx_mul(t, d));
        return p >= bmin && p <= bmax;
    endfunction

    function bit takes(longint t, longint near, longint o[3], longint d[3]);
        if (!(eps < t && t < near)) return 0;
        return in_box(o[0], t, d[0]) && in_box(o[1], t, d[1]) && in_box(o[2], t, d[2]);
    endfunction

    function void note(t_ray r);
        longint o[3];
        longint d[3];
        longint a;
        longint b;
        longint c;
        longint near;
        longint t;
        longint disc;
        longint s;
        longint nb;
        bit h;
        o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
        d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
        near = r.nearest;
        t = 0;
        h = 0;
        a = clamp(-fx_mul(d[0], d[1]));
        b = clamp(d[2] - clamp(fx_mul(d[1], o[0]) + fx_mul(d[0], o[1])));
        c = clamp(o[2] - fx_mul(o[0], o[1]));
        if (r.prior) begin
            if (b < -eps && a != 0) begin
                t = fx_div(b, a);
                h = takes(t, near, o, d);
            end
        end else begin
            disc = clamp(fx_mul(b, b) - clamp(4 * fx_mul(a, c)));
            if (disc >= eps && a != 0) begin
                s = fx_sqrt(disc);
                nb = clamp(-b);
                if (a < 0) s = -s;
                t = fx_div(clamp(nb - s), 2 * a);
                h = takes(t, near, o, d);
                if (!h) begin
                    t = fx_div(clamp(nb + s), 2 * a);
                    h = takes(t, near, o, d);
                end
            end
        end
        exp_hit.push_back(h);
        exp_near.push_back(h ? int'(t) : int'(r.nearest));
    endfunction

    function void check(logic h, logic signed [31:0] n);
        bit eh;
        int en;
        checked++;
        if (exp_hit.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: result beat with nothing expected: hit=%0b near=%0d",
                                       h, n);
            return;
        end
        eh = exp_hit.pop_front();
        en = exp_near.pop_front();
        if (eh) hits++;
        if (h !== eh || n !== en) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: result %0d: expected hit=%0b near=%0d, got hit=%0b near=%0d",
                         checked, eh, en, h, n);
        end
    endfunction
endclass

module tb;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN = 80;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_origin_x;
    logic signed [31:0] i_origin_y;
    logic signed [31:0] i_origin_z;
    logic signed [31:0] i_dir_x;
    logic signed [31:0] i_dir_y;
    logic signed [31:0] i_dir_z;
    logic signed [31:0] i_nearest_in;
    logic               i_prior_hit;
    logic               o_valid;
    logic               i_stall;
    logic               o_hit;
    logic signed [31:0] o_nearest_out;

    ray_scoreboard sb;
    int  idle_cycles;
    int  sent;
    bit  quiet;
    bit  hold_req;
    int  cfg_phases;

    ray_saddle_intersect dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // accept beats on both channels and guard against hangs
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note('{i_origin_x, i_origin_y, i_origin_z, i_dir_x, i_dir_y, i_dir_z,
                          i_nearest_in, i_prior_hit});
                sent++;
            end
            if (o_valid && !i_stall) sb.check(o_hit, o_nearest_out);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // result side: random stall per beat, plus one long hold-off on request
    initial begin
        int w;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                @(negedge i_clk);
                i_stall = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_req = 0;
            end
            w = quiet ? 0 : $urandom_range(0, 15);
            repeat (w) begin
                @(negedge i_clk);
                i_stall = 1'b1;
            end
            @(negedge i_clk);
            i_stall = 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_regs(logic [15:0] e, logic signed [31:0] lo, logic signed [31:0] hi);
        // wait out the pipeline before touching registers
        while (sb.exp_hit.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        apb_write(REG_EPSILON, {16'h0, e});
        apb_write(REG_BOX_MIN, lo);
        apb_write(REG_BOX_MAX, hi);
        sb.eps = e;
        sb.bmin = lo;
        sb.bmax = hi;
        cfg_phases++;
    endtask

    task automatic send_ray(t_ray r, int gap);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        {i_origin_x, i_origin_y, i_origin_z, i_dir_x, i_dir_y, i_dir_z,
         i_nearest_in, i_prior_hit} = r;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic logic signed [31:0] near_coord(int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic t_ray make_ray();
        t_ray r;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), 1'($urandom())};
        end else begin
            // rays around the unit cube, where hits actually happen
            r.ox = near_coord(131072);
            r.oy = near_coord(131072);
            r.oz = near_coord(131072);
            r.dx = near_coord(131072);
            r.dy = near_coord(131072);
            r.dz = near_coord(131072);
            r.nearest = ($urandom_range(0, 9) < 7) ? 32'sh7fffffff
                                                   : $signed($urandom_range(0, 400000));
            r.prior = ($urandom_range(0, 3) == 0);
        end
        return r;
    endfunction

    task automatic run_random(int n, bit press);
        int gap;
        for (int k = 0; k < n; k++) begin
            if (k % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
            if (press && k == n / 2) hold_req = 1;
            gap = (quiet || (press && hold_req)) ? 0 : $urandom_range(0, 15);
            send_ray(make_ray(), gap);
        end
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic run_directed();
        t_ray d[$];
        // max / min on every field, zero direction (no leading term), prior both ways
        d.push_back({32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                     32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0});
        d.push_back({32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                     32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1});
        d.push_back({32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                     32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1'b0});
        d.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0});
        d.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd65536,
                     32'sh7fffffff, 1'b1});
        d.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd65536,
                     32'sh7fffffff, 1'b0});
        d.push_back({-32'sd65536, -32'sd65536, 32'sd0, 32'sd65536, 32'sd65536, 32'sd0,
                     32'sh7fffffff, 1'b0});
        d.push_back({-32'sd65536, 32'sd65536, 32'sd0, 32'sd65536, -32'sd65536, 32'sd0,
                     32'sh7fffffff, 1'b0});
        d.push_back({-32'sd65536, 32'sd65536, 32'sd0, 32'sd65536, -32'sd65536, -32'sd131072,
                     32'sh7fffffff, 1'b1});
        d.push_back({-32'sd65536, -32'sd65536, 32'sd0, 32'sd65536, 32'sd65536, 32'sd0,
                     32'sd1000, 1'b0});
        d.push_back({-32'sd65536, -32'sd65536, 32'sd0, 32'sd65536, 32'sd65536, 32'sd0,
                     -32'sd5, 1'b0});
        d.push_back({32'sd32768, 32'sd32768, 32'sd16384, 32'sd1, 32'sd1, 32'sd1,
                     32'sh7fffffff, 1'b0});
        d.push_back({32'sh7fffffff, 32'sd0, 32'sd0, 32'sd0, 32'sh80000000, 32'sd0,
                     32'sh7fffffff, 1'b1});
        foreach (d[i]) send_ray(d[i], i % 3);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    initial begin
        sb = new();
        idle_cycles = 0;
        sent = 0;
        quiet = 0;
        hold_req = 0;
        cfg_phases = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_valid = 1'b0;
        {i_origin_x, i_origin_y, i_origin_z, i_dir_x, i_dir_y, i_dir_z,
         i_nearest_in, i_prior_hit} = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        run_random(250, 1);
        set_regs(16'd0, 32'sh80000000, 32'sh7fffffff);
        run_directed();
        run_random(150, 0);
        set_regs(16'hffff, -32'sd131072, 32'sd131072);
        run_random(150, 0);
        // inverted cube: every candidate falls outside
        set_regs(16'd100, 32'sd65536, -32'sd65536);
        run_random(60, 0);
        set_regs(16'd16, -32'sd32768, 32'sd98304);
        run_random(190, 0);

        while (sb.exp_hit.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        $display("Covered %0d rays over %0d register settings; %0d results checked, %0d hits.",
                 sent, cfg_phases + 1, sb.checked, sb.hits);
        if (sb.errors == 0 && sb.exp_hit.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.exp_hit.size());
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
